### rtl/core/stcp_pkg.sv
package stcp_pkg;

  // Item codes
  localparam logic [1:0] ACT_BYTE  = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  localparam logic [1:0] KIND_SET   = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_VALID_MASK = 2'd0;
  localparam logic [1:0] REG_ARM_HOLD   = 2'd1;
  localparam logic [1:0] REG_AUTOKILL   = 2'd2;

  localparam logic [7:0]  SYNC_BYTE      = 8'hAA;
  localparam logic [7:0]  CMD_SET_TARGET = 8'h84;
  localparam logic [14:0] NEUTRAL_PULSE  = 15'd6000;
  localparam int unsigned MAX_CHANNELS   = 8;

  localparam logic [7:0]  MASK_RESET     = 8'd255;
  localparam logic [15:0] ARM_HOLD_RESET = 16'd155;
  localparam logic [15:0] AUTOKILL_RESET = 16'd1000;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CHAN = 2'd1,
    PH_LOW  = 2'd2,
    PH_HIGH = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic [2:0] query_channel;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  channel;
    logic [14:0] pulse;
    logic        active;
  } out_item_t;

endpackage

### rtl/core/servo_target_command_parser_top.sv
// Servo set-target command parser. Each request on the input channel is a
// received serial byte, a one-millisecond tick, or a query about one channel.
// Bytes are dropped until the 0xAA sync byte; after that the block stays synced
// and decodes 0x84 <channel> <low 7 bits> <high byte> commands into a 15-bit
// pulse per channel. Each channel also holds an autokill countdown (pulse reads
// as neutral 6000 once it runs out) and an arming countdown restarted by a
// neutral command (channel reads active once it runs out). A set command, a
// query, or a rejected channel byte yields one result request; ticks and other
// bytes yield none. Every request is taken whole, and a new one can be accepted
// every cycle unless a result is held in the full output register: the whole decode and the per-channel update sit in
// one combinational pass between the request and the output register, and
// all countdowns decrement in parallel on a tick. A result shows up on the
// output in the cycle after its request is accepted. The output register holds
// one result; while it is full and out_ready is low, every request is held
// off, whether or not it would produce a result. All channel state lives in
// flip-flops, so reset restores it at once with no clearing pass. The
// configuration port is always ready; write it only while the block is idle.
module servo_target_command_parser_top
  import stcp_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Only channels below eight can ever be mapped, so store no more than that.
  localparam int NCH = (CHANNELS < MAX_CHANNELS) ? CHANNELS : MAX_CHANNELS;

  // Configuration
  logic [7:0]  valid_channel_mask;
  logic [15:0] arm_hold_ticks;
  logic [15:0] autokill_ticks;

  // Parser state
  logic        synced, synced_next;
  phase_t      parse_phase, parse_phase_next;
  logic [2:0]  pending_channel, pending_channel_next;
  logic [6:0]  low_data_bits, low_data_bits_next;

  // Per-channel state
  logic [14:0] channel_pulse [NCH];
  logic [14:0] channel_pulse_next [NCH];
  logic [15:0] arm_countdown [NCH];
  logic [15:0] arm_countdown_next [NCH];
  logic [15:0] kill_countdown [NCH];
  logic [15:0] kill_countdown_next [NCH];

  logic        accept;
  logic [2:0]  rd_sel;
  logic [14:0] rd_pulse;
  logic [15:0] rd_arm;
  logic [15:0] rd_kill;
  logic        res_valid;
  out_item_t   res;

  function automatic logic is_mapped(input logic [7:0] c, input logic [7:0] mask);
    logic ok;
    ok = (32'(c) < CHANNELS) && (32'(c) < MAX_CHANNELS);
    return ok && mask[c[2:0]];
  endfunction

  assign cfg_ready = 1'b1;
  // Hold off input only while a result is stuck in the output register.
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  // One read port into the channel array, steered by the kind of request.
  assign rd_sel = (in_data.action == ACT_QUERY) ? in_data.query_channel : pending_channel;

  always_comb begin
    rd_pulse = NEUTRAL_PULSE;
    rd_arm   = '0;
    rd_kill  = '0;
    for (int i = 0; i < NCH; i++) begin
      if (3'(i) == rd_sel) begin
        rd_pulse = channel_pulse[i];
        rd_arm   = arm_countdown[i];
        rd_kill  = kill_countdown[i];
      end
    end
  end

  always_comb begin
    logic [14:0] new_pulse;
    logic        neutral;
    synced_next          = synced;
    parse_phase_next     = parse_phase;
    pending_channel_next = pending_channel;
    low_data_bits_next   = low_data_bits;
    for (int i = 0; i < NCH; i++) begin
      channel_pulse_next[i]  = channel_pulse[i];
      arm_countdown_next[i]  = arm_countdown[i];
      kill_countdown_next[i] = kill_countdown[i];
    end
    res_valid = 1'b0;
    res       = '{kind: KIND_ERROR, channel: 8'd0, pulse: 15'd0, active: 1'b0};
    new_pulse = {in_data.rx_byte, low_data_bits};
    neutral   = (new_pulse == NEUTRAL_PULSE);

    if (accept) begin
      case (in_data.action)
        ACT_TICK: begin
          // Every countdown steps down together and sticks at zero.
          for (int i = 0; i < NCH; i++) begin
            if (arm_countdown[i] != '0) arm_countdown_next[i] = arm_countdown[i] - 16'd1;
            if (kill_countdown[i] != '0) kill_countdown_next[i] = kill_countdown[i] - 16'd1;
          end
        end
        ACT_QUERY: begin
          res_valid = 1'b1;
          if (is_mapped({5'd0, in_data.query_channel}, valid_channel_mask)) begin
            res.kind    = KIND_QUERY;
            res.channel = {5'd0, in_data.query_channel};
            res.pulse   = (rd_kill == '0) ? NEUTRAL_PULSE : rd_pulse;
            res.active  = (rd_arm == '0);
          end else begin
            res.channel = {5'd0, in_data.query_channel};
          end
        end
        ACT_BYTE: begin
          if (!synced) begin
            // Drop everything until the sync byte shows up.
            if (in_data.rx_byte == SYNC_BYTE) begin
              synced_next          = 1'b1;
              parse_phase_next     = PH_IDLE;
              pending_channel_next = '0;
            end
          end else begin
            case (parse_phase)
              PH_IDLE: begin
                if (in_data.rx_byte == CMD_SET_TARGET) parse_phase_next = PH_CHAN;
              end
              PH_CHAN: begin
                if (!is_mapped(in_data.rx_byte, valid_channel_mask)) begin
                  // Reject the raw byte and start over.
                  parse_phase_next = PH_IDLE;
                  res_valid        = 1'b1;
                  res.channel      = in_data.rx_byte;
                end else begin
                  pending_channel_next = in_data.rx_byte[2:0];
                  parse_phase_next     = PH_LOW;
                end
              end
              PH_LOW: begin
                low_data_bits_next = in_data.rx_byte[6:0];
                parse_phase_next   = PH_HIGH;
              end
              PH_HIGH: begin
                parse_phase_next = PH_IDLE;
                if (32'(pending_channel) < CHANNELS) begin
                  for (int i = 0; i < NCH; i++) begin
                    if (3'(i) == pending_channel) begin
                      channel_pulse_next[i]  = new_pulse;
                      kill_countdown_next[i] = autokill_ticks;
                      if (neutral) arm_countdown_next[i] = arm_hold_ticks;
                    end
                  end
                  // Report the channel as it reads after this command.
                  res_valid   = 1'b1;
                  res.kind    = KIND_SET;
                  res.channel = {5'd0, pending_channel};
                  res.pulse   = (autokill_ticks == '0) ? NEUTRAL_PULSE : new_pulse;
                  res.active  = neutral ? (arm_hold_ticks == '0) : (rd_arm == '0);
                end
              end
              default: parse_phase_next = PH_IDLE;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // Parser and channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      synced          <= 1'b0;
      parse_phase     <= PH_IDLE;
      pending_channel <= '0;
      low_data_bits   <= '0;
      for (int i = 0; i < NCH; i++) begin
        channel_pulse[i]  <= NEUTRAL_PULSE;
        arm_countdown[i]  <= '0;
        kill_countdown[i] <= '0;
      end
    end else begin
      synced          <= synced_next;
      parse_phase     <= parse_phase_next;
      pending_channel <= pending_channel_next;
      low_data_bits   <= low_data_bits_next;
      for (int i = 0; i < NCH; i++) begin
        channel_pulse[i]  <= channel_pulse_next[i];
        arm_countdown[i]  <= arm_countdown_next[i];
        kill_countdown[i] <= kill_countdown_next[i];
      end
    end
  end

  // Configuration writes; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_channel_mask <= MASK_RESET;
      arm_hold_ticks     <= ARM_HOLD_RESET;
      autokill_ticks     <= AUTOKILL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_VALID_MASK: valid_channel_mask <= cfg_data[7:0];
        REG_ARM_HOLD:   arm_hold_ticks     <= cfg_data;
        REG_AUTOKILL:   autokill_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Output register: load a new result, or drop the old one once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_data <= res;
    end
  end

endmodule

### bench/servo_target_command_parser_top_tb.sv
`timescale 1ns / 1ps

module servo_target_command_parser_top_tb;
  import stcp_pkg::*;

  localparam int          CHANNELS       = 8;
  localparam logic [1:0]  ACT_UNUSED     = 2'd3;   // undefined action, block drops it
  localparam int          STALL_CYCLES   = 300;    // long receiver hold-off
  localparam int          DRAIN_CYCLES   = 6;      // output register plus margin
  localparam int          WATCHDOG_LIMIT = 2000;   // quiet cycles before giving up

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  servo_target_command_parser_top #(
    .CHANNELS(CHANNELS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow copy of the configuration registers, updated at each accepted write.
  logic [7:0]  mask_reg;
  logic [15:0] arm_hold_reg;
  logic [15:0] autokill_reg;

  // Shadow copy of the parser and of the per-channel timers.
  logic        servo_synced;
  phase_t      cmd_phase;
  logic [2:0]  cmd_channel;
  logic [6:0]  cmd_low7;
  logic [14:0] ch_pulse     [CHANNELS];
  logic [15:0] ch_arm_left  [CHANNELS];
  logic [15:0] ch_kill_left [CHANNELS];

  in_item_t  tx_requests [$];   // requests waiting for the driver
  out_item_t due_reports [$];   // reports the block still owes, oldest first
  out_item_t head_report;

  int   queued_count   = 0;
  int   accepted_count = 0;
  int   error_count    = 0;
  int   quiet_cycles   = 0;
  int   hold_left;
  logic hold_off_done;
  logic hold_off_req = 1'b0;    // ask the monitor for one long stall
  logic calm         = 1'b0;    // suppress random idling on both sides

  function automatic logic channel_mapped(input logic [7:0] c);
    return (c < CHANNELS) && (c < MAX_CHANNELS) && mask_reg[c[2:0]];
  endfunction

  // Report for a mapped channel: pulse falls back to neutral once the
  // autokill countdown has run out, active once the arming countdown has.
  function automatic out_item_t channel_status(input logic [1:0] k, input logic [2:0] c);
    out_item_t rep;
    rep.kind    = k;
    rep.channel = {5'd0, c};
    rep.pulse   = (ch_kill_left[c] == 16'd0) ? NEUTRAL_PULSE : ch_pulse[c];
    rep.active  = (ch_arm_left[c] == 16'd0);
    return rep;
  endfunction

  // Advance the shadow state by one accepted request and queue any report it owes.
  task automatic decode_request(input in_item_t r);
    out_item_t   rep;
    logic [14:0] p;
    case (r.action)
      ACT_TICK: begin
        // All countdowns step down together and stick at zero.
        for (int i = 0; i < CHANNELS; i++) begin
          if (ch_arm_left[i] != 16'd0) ch_arm_left[i] = ch_arm_left[i] - 16'd1;
          if (ch_kill_left[i] != 16'd0) ch_kill_left[i] = ch_kill_left[i] - 16'd1;
        end
      end
      ACT_QUERY: begin
        if (!channel_mapped({5'd0, r.query_channel})) begin
          rep = '0;
          rep.kind    = KIND_ERROR;
          rep.channel = {5'd0, r.query_channel};
          due_reports.push_back(rep);
        end else begin
          due_reports.push_back(channel_status(KIND_QUERY, r.query_channel));
        end
      end
      ACT_BYTE: begin
        if (!servo_synced) begin
          // Drop everything until the sync byte; after that stay synced.
          if (r.rx_byte == SYNC_BYTE) begin
            servo_synced = 1'b1;
            cmd_phase    = PH_IDLE;
            cmd_channel  = 3'd0;
          end
        end else begin
          case (cmd_phase)
            PH_IDLE: begin
              if (r.rx_byte == CMD_SET_TARGET) cmd_phase = PH_CHAN;
            end
            PH_CHAN: begin
              if (!channel_mapped(r.rx_byte)) begin
                // Reject with the raw byte and go back to idle.
                cmd_phase   = PH_IDLE;
                rep         = '0;
                rep.kind    = KIND_ERROR;
                rep.channel = r.rx_byte;
                due_reports.push_back(rep);
              end else begin
                cmd_channel = r.rx_byte[2:0];
                cmd_phase   = PH_LOW;
              end
            end
            PH_LOW: begin
              cmd_low7  = r.rx_byte[6:0];
              cmd_phase = PH_HIGH;
            end
            default: begin
              // High byte enters whole, so the pulse spans 15 bits.
              p         = {r.rx_byte, cmd_low7};
              cmd_phase = PH_IDLE;
              if (p == NEUTRAL_PULSE) ch_arm_left[cmd_channel] = arm_hold_reg;
              ch_pulse[cmd_channel]     = p;
              ch_kill_left[cmd_channel] = autokill_reg;
              due_reports.push_back(channel_status(KIND_SET, cmd_channel));
            end
          endcase
        end
      end
      default: ;
    endcase
  endtask

  // Driver: hold the request until accepted, then advance to the next one.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_request(in_data);
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (tx_requests.size() != 0 && (calm || $urandom_range(99) >= 21)) begin
          in_data  <= tx_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare every accepted report with the oldest one still due.
  always @(posedge clk) begin
    if (rst) begin
      out_ready     <= 1'b0;
      hold_left     <= 0;
      hold_off_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_reports.size() == 0) begin
          $error("report with none due: kind %0d channel %0d pulse %0d active %0d",
                 out_data.kind, out_data.channel, out_data.pulse, out_data.active);
          error_count++;
        end else begin
          head_report = due_reports.pop_front();
          if (out_data.kind !== head_report.kind) begin
            $error("kind: expected %0d, actual %0d", head_report.kind, out_data.kind);
            error_count++;
          end
          if (out_data.channel !== head_report.channel) begin
            $error("channel: expected %0d, actual %0d", head_report.channel, out_data.channel);
            error_count++;
          end
          if (out_data.pulse !== head_report.pulse) begin
            $error("pulse: expected %0d, actual %0d", head_report.pulse, out_data.pulse);
            error_count++;
          end
          if (out_data.active !== head_report.active) begin
            $error("active: expected %0d, actual %0d", head_report.active, out_data.active);
            error_count++;
          end
        end
      end
      // One long hold-off on request, otherwise random back-pressure.
      if (hold_off_req && !hold_off_done) begin
        hold_off_done <= 1'b1;
        hold_left     <= STALL_CYCLES;
        out_ready     <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 21);
      end
    end
  end

  // Watchdog: give up after too many cycles with no handshake on any port.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_request(input logic [1:0] act, input logic [7:0] rx,
                               input logic [2:0] qc);
    in_item_t req;
    req.action        = act;
    req.rx_byte       = rx;
    req.query_channel = qc;
    tx_requests.push_back(req);
    queued_count++;
  endtask

  task automatic queue_command(input logic [7:0] ch, input logic [7:0] lo,
                               input logic [7:0] hi);
    queue_request(ACT_BYTE, CMD_SET_TARGET, 3'd0);
    queue_request(ACT_BYTE, ch, 3'd0);
    queue_request(ACT_BYTE, lo, 3'd0);
    queue_request(ACT_BYTE, hi, 3'd0);
  endtask

  // Mostly well-formed set-target commands with random content, mixed with
  // ticks, queries, stray bytes and undefined actions.
  task automatic queue_random_traffic(input int n);
    int         made;
    int         pick;
    logic [7:0] ch;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [2:0] qc;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      lo   = 8'($urandom);
      hi   = 8'($urandom);
      qc   = 3'($urandom);
      if (pick < 45) begin
        // Stay mostly on real channels, sometimes throw in any byte.
        if ($urandom_range(9) == 0) ch = 8'($urandom);
        else ch = 8'($urandom_range(CHANNELS - 1));
        if ($urandom_range(3) == 0) queue_command(ch, {lo[7], 7'h70}, 8'h2E);
        else queue_command(ch, lo, hi);
        made += 4;
      end else begin
        if (pick < 65) queue_request(ACT_TICK, lo, qc);
        else if (pick < 85) queue_request(ACT_QUERY, lo, qc);
        else if (pick < 95) queue_request(ACT_BYTE, lo, qc);
        else queue_request(ACT_UNUSED, lo, qc);
        made++;
      end
    end
  endtask

  // Block until every queued request is accepted and every report has come,
  // then let the pipeline settle.
  task automatic wait_idle();
    while (accepted_count != queued_count || due_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      REG_VALID_MASK: mask_reg     = val[7:0];
      REG_ARM_HOLD:   arm_hold_reg = val;
      REG_AUTOKILL:   autokill_reg = val;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [7:0] m, input logic [15:0] arm,
                           input logic [15:0] kill);
    write_reg(REG_VALID_MASK, {8'd0, m});
    write_reg(REG_ARM_HOLD, arm);
    write_reg(REG_AUTOKILL, kill);
  endtask

  initial begin
    // Known values on every input from time zero.
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_VALID_MASK;
    cfg_data  = '0;

    mask_reg     = MASK_RESET;
    arm_hold_reg = ARM_HOLD_RESET;
    autokill_reg = AUTOKILL_RESET;
    servo_synced = 1'b0;
    cmd_phase    = PH_IDLE;
    cmd_channel  = 3'd0;
    cmd_low7     = 7'd0;
    for (int i = 0; i < CHANNELS; i++) begin
      ch_pulse[i]     = NEUTRAL_PULSE;
      ch_arm_left[i]  = 16'd0;
      ch_kill_left[i] = 16'd0;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset configuration. Bytes before sync are dropped, even a
    // set-target command byte; queries and undefined actions still work.
    queue_request(ACT_BYTE, CMD_SET_TARGET, 3'd0);
    queue_request(ACT_QUERY, 8'd0, 3'd7);
    queue_request(ACT_UNUSED, 8'hFF, 3'd7);
    queue_request(ACT_BYTE, SYNC_BYTE, 3'd0);
    // A second sync byte is just an ordinary byte in idle.
    queue_request(ACT_BYTE, SYNC_BYTE, 3'd0);
    // Largest pulse on the top channel.
    queue_command(8'd7, 8'h7F, 8'hFF);
    // Channel byte out of range: error with the raw byte.
    queue_request(ACT_BYTE, CMD_SET_TARGET, 3'd0);
    queue_request(ACT_BYTE, 8'hFF, 3'd0);
    // Neutral command restarts arming, so the channel reads inactive.
    queue_command(8'd0, 8'h70, 8'h2E);
    queue_request(ACT_TICK, 8'h00, 3'd0);
    queue_request(ACT_QUERY, 8'hFF, 3'd0);
    wait_idle();

    // Directed, sparse mask with zero arming hold and zero autokill.
    write_all(8'h5A, 16'd0, 16'd0);
    queue_command(8'd1, 8'h70, 8'h2E);
    queue_request(ACT_BYTE, CMD_SET_TARGET, 3'd0);
    queue_request(ACT_BYTE, 8'd0, 3'd0);
    queue_request(ACT_QUERY, 8'd0, 3'd0);
    wait_idle();

    // Random traffic with short timers so kills and arming expire often.
    // Stall the receiver long enough for the block to fill and push back.
    write_all(8'hFF, 16'd4, 16'd12);
    queue_random_traffic(200);
    hold_off_req <= 1'b1;
    // Pause the sender until every report is back, then carry on.
    wait_idle();
    queue_random_traffic(200);
    wait_idle();

    // Random mask and timers, no idling on either side.
    write_all(8'($urandom_range(255)), 16'($urandom_range(8)), 16'($urandom_range(20)));
    calm <= 1'b1;
    queue_random_traffic(300);
    wait_idle();
    calm <= 1'b0;

    // Longest timers: countdowns started here never run out.
    write_all(8'hFF, 16'hFFFF, 16'hFFFF);
    queue_random_traffic(250);
    wait_idle();

    // Every channel unmapped: all commands and queries end in errors.
    write_all(8'h00, 16'd1, 16'd1);
    queue_random_traffic(100);
    wait_idle();

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
